@@ rtl/number_to_ascii_digits_macros.svh @@
// assertion macros for the number to ascii digits block
`ifndef NUMBER_TO_ASCII_DIGITS_MACROS_SVH
`define NUMBER_TO_ASCII_DIGITS_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define NTA_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define NTA_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/nta_pkg.sv @@
// shared types and constants for the number to ascii digits block
`default_nettype none

package nta_pkg;

  localparam int VALUE_BITS = 32;
  localparam int CONV_CNT_W = $clog2(VALUE_BITS);
  localparam logic [CONV_CNT_W-1:0] CONV_LAST = CONV_CNT_W'(VALUE_BITS - 1);

  localparam int DEC_DIGITS = 10;
  localparam int HEX_DIGITS = 8;
  localparam int BIN_DIGITS = 32;

  localparam logic [5:0] MAX_DEC = 6'd10;
  localparam logic [5:0] MAX_HEX = 6'd8;
  localparam logic [5:0] MAX_BIN = 6'd32;

  localparam logic [1:0] KIND_UDEC = 2'd0;
  localparam logic [1:0] KIND_SDEC = 2'd1;
  localparam logic [1:0] KIND_HEX  = 2'd2;
  localparam logic [1:0] KIND_BIN  = 2'd3;

  localparam logic [6:0] CH_ZERO  = 7'h30;
  localparam logic [6:0] CH_A     = 7'h41;
  localparam logic [6:0] CH_PLUS  = 7'h2B;
  localparam logic [6:0] CH_MINUS = 7'h2D;

  typedef logic [VALUE_BITS-1:0] val_t;
  typedef logic [3:0] bcd_digit_t;
  typedef bcd_digit_t [DEC_DIGITS-1:0] bcd_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic clear;
    logic shift;
  } chain_ctrl_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] number;
    logic [5:0]  digit_count;
    logic [2:0]  text_line;
    logic [4:0]  start_column;
  } in_item_t;

  typedef struct packed {
    logic [6:0] char_code;
    logic [2:0] out_line;
    logic [5:0] out_column;
    logic       last;
  } out_item_t;

endpackage

`default_nettype wire

@@ rtl/nta_bcd_cell.sv @@
// one decimal digit cell of the shift-and-add-3 chain
`default_nettype none

module nta_bcd_cell (
  input  wire logic                 clk,
  input  wire nta_pkg::chain_ctrl_t ctrl,
  input  wire logic                 shift_in,
  output logic                      shift_out,
  output nta_pkg::bcd_digit_t       digit
);

  nta_pkg::bcd_digit_t digit_r;
  nta_pkg::bcd_digit_t digit_nxt;
  nta_pkg::bcd_digit_t adj;

  always_comb begin
    adj = (digit_r >= 4'd5) ? digit_r + 4'd3 : digit_r;
    shift_out = adj[3];
    digit_nxt = digit_r;
    if (ctrl.clear) begin
      digit_nxt = '0;
    end else if (ctrl.shift) begin
      digit_nxt = {adj[2:0], shift_in};
    end
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

  assign digit = digit_r;

endmodule

`default_nettype wire

@@ rtl/nta_digit_chain.sv @@
// row of decimal digit cells, least significant cell takes the value bits
`default_nettype none

module nta_digit_chain (
  input  wire logic                 clk,
  input  wire nta_pkg::chain_ctrl_t ctrl,
  input  wire logic                 bit_in,
  output nta_pkg::bcd_word_t        digits
);

  logic [nta_pkg::DEC_DIGITS:0] link;

  assign link[0] = bit_in;

  for (genvar i = 0; i < nta_pkg::DEC_DIGITS; i++) begin : g_cell
    nta_bcd_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .shift_in  (link[i]),
      .shift_out (link[i+1]),
      .digit     (digits[i])
    );
  end

  // top carry never sets since the value fits in the digit row
  logic unused_carry;
  assign unused_carry = link[nta_pkg::DEC_DIGITS];

endmodule

`default_nettype wire

@@ rtl/number_to_ascii_digits.sv @@
// top level: formats one number as fixed-width ascii characters
//
// input: a transaction is taken at a clock edge with start high and busy low;
// in_data carries kind, number, digit count, text line and start column.
// output: one character per cycle on out_data, marked by out_valid for
// exactly one cycle; the receiver cannot stall, so nothing is held back.
// decimal kinds first run the value through a row of ten digit cells, one
// value bit per cycle, then emit the sign if any and the digits.
// hex and binary go straight to emission.
// the next start can be taken on the cycle the last character is shown.
// reset (rst_n low, synchronous) returns to idle and drops any pending output.
`default_nettype none

module number_to_ascii_digits (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire nta_pkg::in_item_t  in_data,
  output logic                    out_valid,
  output nta_pkg::out_item_t      out_data
);

  `include "number_to_ascii_digits_macros.svh"

  nta_pkg::state_t state_r;
  nta_pkg::state_t state_nxt;

  logic [1:0]                        kind_r;
  logic [2:0]                        line_r;
  logic [4:0]                        col_r;
  logic                              neg_r;
  logic [5:0]                        last_idx_r;
  logic [5:0]                        cnt_r;
  logic [nta_pkg::CONV_CNT_W-1:0]    conv_cnt_r;
  nta_pkg::val_t                     val_r;
  nta_pkg::out_item_t                out_r;
  logic                              out_valid_r;

  logic [5:0]                        last_idx_nxt;
  logic [5:0]                        cnt_nxt;
  logic [nta_pkg::CONV_CNT_W-1:0]    conv_cnt_nxt;
  nta_pkg::val_t                     val_nxt;
  logic                              neg_nxt;
  nta_pkg::out_item_t                out_nxt;

  logic                  accept;
  logic                  in_is_dec;
  logic                  emit;
  nta_pkg::chain_ctrl_t  ctrl;
  nta_pkg::bcd_word_t    digits;
  nta_pkg::val_t         in_val;
  logic [5:0]            lim;
  logic [5:0]            n_sel;
  logic [5:0]            pos;
  logic [nta_pkg::BIN_DIGITS-1:0] val_ext;
  logic [nta_pkg::HEX_DIGITS-1:0][3:0] val_nib;
  nta_pkg::bcd_digit_t   dec_digit;
  logic [3:0]            hex_digit;
  logic [6:0]            ch;

  assign busy      = (state_r != nta_pkg::ST_IDLE);
  assign accept    = start && !busy;
  assign in_is_dec = (in_data.kind == nta_pkg::KIND_UDEC) ||
                     (in_data.kind == nta_pkg::KIND_SDEC);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      nta_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = in_is_dec ? nta_pkg::ST_CONV : nta_pkg::ST_EMIT;
        end
      end
      nta_pkg::ST_CONV: begin
        if (conv_cnt_r == nta_pkg::CONV_LAST) begin
          state_nxt = nta_pkg::ST_EMIT;
        end
      end
      nta_pkg::ST_EMIT: begin
        if (cnt_r == last_idx_r) begin
          state_nxt = nta_pkg::ST_IDLE;
        end
      end
      default: state_nxt = nta_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    ctrl = '0;
    emit = 1'b0;
    unique case (state_r)
      nta_pkg::ST_IDLE: ctrl.clear = accept;
      nta_pkg::ST_CONV: ctrl.shift = 1'b1;
      nta_pkg::ST_EMIT: emit = 1'b1;
      default: begin
        ctrl = '0;
        emit = 1'b0;
      end
    endcase
  end

  nta_digit_chain u_chain (
    .clk    (clk),
    .ctrl   (ctrl),
    .bit_in (val_r[nta_pkg::VALUE_BITS-1]),
    .digits (digits)
  );

  // digit count clamp and input value for the load
  always_comb begin
    in_val = in_data.number[nta_pkg::VALUE_BITS-1:0];
    unique case (in_data.kind) inside
      nta_pkg::KIND_UDEC, nta_pkg::KIND_SDEC: lim = nta_pkg::MAX_DEC;
      nta_pkg::KIND_HEX:                      lim = nta_pkg::MAX_HEX;
      default:                                lim = nta_pkg::MAX_BIN;
    endcase
    if (in_data.digit_count == 6'd0) begin
      n_sel = 6'd1;
    end else if (in_data.digit_count > lim) begin
      n_sel = lim;
    end else begin
      n_sel = in_data.digit_count;
    end
  end

  // character selection
  always_comb begin
    pos       = last_idx_r - cnt_r;
    val_ext   = '0;
    val_ext[nta_pkg::VALUE_BITS-1:0] = val_r;
    val_nib   = val_ext;
    dec_digit = digits[pos[3:0]];
    hex_digit = val_nib[pos[2:0]];
    unique case (kind_r)
      nta_pkg::KIND_UDEC: ch = nta_pkg::CH_ZERO + {3'b000, dec_digit};
      nta_pkg::KIND_SDEC: begin
        if (cnt_r == 6'd0) begin
          ch = neg_r ? nta_pkg::CH_MINUS : nta_pkg::CH_PLUS;
        end else begin
          ch = nta_pkg::CH_ZERO + {3'b000, dec_digit};
        end
      end
      nta_pkg::KIND_HEX: begin
        if (hex_digit < 4'd10) begin
          ch = nta_pkg::CH_ZERO + {3'b000, hex_digit};
        end else begin
          ch = nta_pkg::CH_A + {3'b000, hex_digit} - 7'd10;
        end
      end
      default: ch = nta_pkg::CH_ZERO + {6'b000000, val_ext[pos[4:0]]};
    endcase
  end

  // datapath next values
  always_comb begin
    last_idx_nxt = last_idx_r;
    cnt_nxt      = cnt_r;
    conv_cnt_nxt = conv_cnt_r;
    val_nxt      = val_r;
    neg_nxt      = neg_r;
    out_nxt      = out_r;
    if (accept) begin
      neg_nxt      = (in_data.kind == nta_pkg::KIND_SDEC) && in_val[nta_pkg::VALUE_BITS-1];
      val_nxt      = neg_nxt ? nta_pkg::val_t'(~in_val + 1'b1) : in_val;
      last_idx_nxt = n_sel - 6'd1 + {5'b00000, in_data.kind == nta_pkg::KIND_SDEC};
      cnt_nxt      = '0;
      conv_cnt_nxt = '0;
    end else if (ctrl.shift) begin
      val_nxt      = {val_r[nta_pkg::VALUE_BITS-2:0], 1'b0};
      conv_cnt_nxt = conv_cnt_r + 1'b1;
    end else if (emit) begin
      cnt_nxt            = cnt_r + 6'd1;
      out_nxt.char_code  = ch;
      out_nxt.out_line   = line_r;
      out_nxt.out_column = {1'b0, col_r} + cnt_r;
      out_nxt.last       = (cnt_r == last_idx_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nta_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= in_data.kind;
      line_r <= in_data.text_line;
      col_r  <= in_data.start_column;
    end
    neg_r      <= neg_nxt;
    last_idx_r <= last_idx_nxt;
    cnt_r      <= cnt_nxt;
    conv_cnt_r <= conv_cnt_nxt;
    val_r      <= val_nxt;
    out_r      <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `NTA_ASSERT_IMPL(a_out_only_after_emit, out_valid_r, $past(state_r == nta_pkg::ST_EMIT), "character shown without an emit cycle")
  `NTA_ASSERT_NEXT(a_accept_leaves_idle, start && !busy, state_r != nta_pkg::ST_IDLE, "accepted transaction did not start work")
  `NTA_ASSERT_NEXT(a_last_on_final, state_r == nta_pkg::ST_EMIT && cnt_r == last_idx_r, out_valid_r && out_r.last, "final character not flagged last")
  `NTA_ASSERT_IMPL(a_dec_digit_range, state_r == nta_pkg::ST_EMIT && kind_r == nta_pkg::KIND_UDEC, dec_digit < 4'd10, "digit chain produced a non-decimal digit")

endmodule

`default_nettype wire

@@ verif/tb_number_to_ascii_digits.sv @@
`timescale 1ns / 1ps
// self-checking testbench for number_to_ascii_digits: directed table plus random numbers
module tb_number_to_ascii_digits;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  nta_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  nta_pkg::out_item_t out_data;

  nta_pkg::out_item_t pending_chars[$];
  nta_pkg::out_item_t head_char;
  nta_pkg::in_item_t  row_items[$];
  string              row_texts[$];
  int                 gap_pct = 0;
  int                 numbers_sent = 0;
  int                 chars_checked = 0;
  int                 errors = 0;
  int                 kind_count[4] = '{0, 0, 0, 0};

  always #5 clk = ~clk;

  number_to_ascii_digits dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  function automatic logic [5:0] clamp_digits(logic [5:0] cnt, logic [5:0] lim);
    if (cnt == 6'd0) return 6'd1;
    if (cnt > lim) return lim;
    return cnt;
  endfunction

  function automatic void push_char(logic [6:0] code, nta_pkg::in_item_t it, int k,
                                    logic is_last);
    nta_pkg::out_item_t c;
    c.char_code  = code;
    c.out_line   = it.text_line;
    c.out_column = 6'(it.start_column) + 6'(k);
    c.last       = is_last;
    pending_chars.push_back(c);
  endfunction

  function automatic void predict_chars(nta_pkg::in_item_t it);
    logic [31:0]     vmask;
    logic [31:0]     mag;
    longint unsigned wide_mag;
    longint unsigned pw;
    logic [3:0]      d;
    logic [6:0]      ch;
    int              nd;
    int              total;
    int              k;
    int              i;
    vmask = 32'((64'd1 << nta_pkg::VALUE_BITS) - 64'd1);
    mag = it.number & vmask;
    k = 0;
    if (it.kind == nta_pkg::KIND_UDEC || it.kind == nta_pkg::KIND_SDEC) begin
      nd = int'(clamp_digits(it.digit_count, nta_pkg::MAX_DEC));
      total = nd + ((it.kind == nta_pkg::KIND_SDEC) ? 1 : 0);
      if (it.kind == nta_pkg::KIND_SDEC) begin
        if (mag[nta_pkg::VALUE_BITS-1]) begin
          mag = (~mag + 32'd1) & vmask;
          push_char(nta_pkg::CH_MINUS, it, k, 1'b0);
        end else begin
          push_char(nta_pkg::CH_PLUS, it, k, 1'b0);
        end
        k++;
      end
      wide_mag = mag;
      pw = 1;
      for (i = 1; i < nd; i++) pw = pw * 10;
      for (i = 0; i < nd; i++) begin
        d = 4'((wide_mag / pw) % 10);
        push_char(nta_pkg::CH_ZERO + 7'(d), it, k, k == total - 1);
        k++;
        pw = pw / 10;
      end
    end else if (it.kind == nta_pkg::KIND_HEX) begin
      nd = int'(clamp_digits(it.digit_count, nta_pkg::MAX_HEX));
      for (i = 0; i < nd; i++) begin
        d = 4'(mag >> (4 * (nd - 1 - i)));
        ch = (d < 4'd10) ? nta_pkg::CH_ZERO + 7'(d) : nta_pkg::CH_A + 7'(d) - 7'd10;
        push_char(ch, it, i, i == nd - 1);
      end
    end else begin
      nd = int'(clamp_digits(it.digit_count, nta_pkg::MAX_BIN));
      for (i = 0; i < nd; i++) begin
        push_char(nta_pkg::CH_ZERO + 7'(mag[nd-1-i]), it, i, i == nd - 1);
      end
    end
  endfunction

  function automatic void push_text(nta_pkg::in_item_t it, string text);
    int i;
    for (i = 0; i < text.len(); i++) begin
      push_char(7'(text[i]), it, i, i == text.len() - 1);
    end
  endfunction

  function automatic nta_pkg::in_item_t random_number_item();
    nta_pkg::in_item_t it;
    int                lim;
    it.kind = 2'($urandom_range(3));
    case ($urandom_range(9))
      0: it.number = 32'h0;
      1: it.number = 32'hFFFF_FFFF;
      2: it.number = 32'h8000_0000;
      3: it.number = 32'h7FFF_FFFF;
      4: it.number = 32'($urandom_range(999));
      5: it.number = 32'(-int'($urandom_range(1000)));
      6: it.number = 32'h1 << $urandom_range(31);
      7: it.number = 32'($urandom_range(99999));
      default: it.number = $urandom();
    endcase
    case (it.kind)
      nta_pkg::KIND_HEX: lim = int'(nta_pkg::MAX_HEX);
      nta_pkg::KIND_BIN: lim = int'(nta_pkg::MAX_BIN);
      default:           lim = int'(nta_pkg::MAX_DEC);
    endcase
    case ($urandom_range(7))
      0: it.digit_count = 6'($urandom_range(63));
      1: it.digit_count = 6'd0;
      default: it.digit_count = 6'($urandom_range(lim, 1));
    endcase
    it.text_line = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(4, 1));
    it.start_column = ($urandom_range(9) == 0) ? 5'($urandom_range(31))
                                               : 5'($urandom_range(16, 1));
    return it;
  endfunction

  task automatic add_row(logic [1:0] kind, logic [31:0] number, logic [5:0] cnt,
                         logic [2:0] line, logic [4:0] col, string text);
    nta_pkg::in_item_t it;
    it.kind         = kind;
    it.number       = number;
    it.digit_count  = cnt;
    it.text_line    = line;
    it.start_column = col;
    row_items.push_back(it);
    row_texts.push_back(text);
  endtask

  // called at a falling edge, returns at the falling edge after the transaction
  task automatic send_number(nta_pkg::in_item_t it, string text);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start   <= 1'b1;
    in_data <= it;
    while (busy) @(negedge clk);
    if (text.len() != 0) push_text(it, text);
    else predict_chars(it);
    numbers_sent++;
    kind_count[it.kind]++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(negedge clk);
    while (pending_chars.size() != 0) @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_chars.size() == 0) begin
        $display("%0t: unexpected character, got char %h line %0d col %0d last %0b",
                 $time, out_data.char_code, out_data.out_line, out_data.out_column,
                 out_data.last);
        errors++;
      end else begin
        head_char = pending_chars.pop_front();
        if (out_data.char_code !== head_char.char_code ||
            out_data.out_line !== head_char.out_line ||
            out_data.out_column !== head_char.out_column ||
            out_data.last !== head_char.last) begin
          $display("%0t: expected %h/%0d/%0d/%0b, got %h/%0d/%0d/%0b (char/line/col/last)",
                   $time, head_char.char_code, head_char.out_line, head_char.out_column,
                   head_char.last, out_data.char_code, out_data.out_line,
                   out_data.out_column, out_data.last);
          errors++;
        end
        chars_checked++;
      end
    end
  end

  initial begin
    #3_000_000;
    $display("** number_to_ascii_digits: FAILED **");
    $finish;
  end

  initial begin
    int phase;
    int i;
    add_row(nta_pkg::KIND_UDEC, 32'h0000_0000, 6'd10, 3'd1, 5'd1,  "0000000000");
    add_row(nta_pkg::KIND_UDEC, 32'hFFFF_FFFF, 6'd10, 3'd4, 5'd16, "4294967295");
    add_row(nta_pkg::KIND_UDEC, 32'hFFFF_FFFF, 6'd63, 3'd2, 5'd5,  "4294967295");
    add_row(nta_pkg::KIND_UDEC, 32'd1234567,   6'd3,  3'd3, 5'd7,  "567");
    add_row(nta_pkg::KIND_UDEC, 32'd5,         6'd0,  3'd1, 5'd1,  "5");
    add_row(nta_pkg::KIND_UDEC, 32'd42,        6'd32, 3'd1, 5'd1,  "0000000042");
    add_row(nta_pkg::KIND_UDEC, 32'd987654321, 6'd9,  3'd7, 5'd31, "");
    add_row(nta_pkg::KIND_SDEC, 32'h0000_0000, 6'd1,  3'd0, 5'd0,  "+0");
    add_row(nta_pkg::KIND_SDEC, 32'h8000_0000, 6'd10, 3'd1, 5'd1,  "-2147483648");
    add_row(nta_pkg::KIND_SDEC, 32'h7FFF_FFFF, 6'd10, 3'd2, 5'd2,  "+2147483647");
    add_row(nta_pkg::KIND_SDEC, 32'hFFFF_FFFF, 6'd40, 3'd4, 5'd3,  "-0000000001");
    add_row(nta_pkg::KIND_SDEC, 32'hFFFF_CFC7, 6'd5,  3'd3, 5'd9,  "");
    add_row(nta_pkg::KIND_SDEC, 32'h8000_0000, 6'd4,  3'd1, 5'd1,  "");
    add_row(nta_pkg::KIND_HEX,  32'hDEAD_BEEF, 6'd8,  3'd1, 5'd1,  "DEADBEEF");
    add_row(nta_pkg::KIND_HEX,  32'h0123_ABCD, 6'd63, 3'd2, 5'd8,  "0123ABCD");
    add_row(nta_pkg::KIND_HEX,  32'hFFFF_FFFF, 6'd0,  3'd3, 5'd16, "F");
    add_row(nta_pkg::KIND_HEX,  32'h89AB_CDEF, 6'd3,  3'd7, 5'd31, "DEF");
    add_row(nta_pkg::KIND_HEX,  32'h0000_0000, 6'd8,  3'd0, 5'd0,  "00000000");
    add_row(nta_pkg::KIND_BIN,  32'h0000_0000, 6'd32, 3'd1, 5'd1,  "");
    add_row(nta_pkg::KIND_BIN,  32'hFFFF_FFFF, 6'd63, 3'd4, 5'd31, "");
    add_row(nta_pkg::KIND_BIN,  32'h0000_00A5, 6'd8,  3'd1, 5'd16, "10100101");
    add_row(nta_pkg::KIND_BIN,  32'h8000_0001, 6'd0,  3'd2, 5'd1,  "1");
    add_row(nta_pkg::KIND_BIN,  32'h5555_AAAA, 6'd32, 3'd7, 5'd0,  "");

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    gap_pct = 8;
    for (i = 0; i < row_items.size(); i++) send_number(row_items[i], row_texts[i]);
    wait_drained();

    for (phase = 0; phase < 3; phase++) begin
      gap_pct = (phase == 0) ? 8 : (phase == 1) ? 51 : 0;
      repeat (120) begin
        send_number(random_number_item(), "");
        if ($urandom_range(39) == 0) wait_drained();
      end
      wait_drained();
    end

    repeat (60) @(negedge clk);
    $display("run covered %0d numbers: %0d unsigned dec, %0d signed dec, %0d hex, %0d bin",
             numbers_sent, kind_count[nta_pkg::KIND_UDEC], kind_count[nta_pkg::KIND_SDEC],
             kind_count[nta_pkg::KIND_HEX], kind_count[nta_pkg::KIND_BIN]);
    $display("%0d characters compared, %0d mismatches", chars_checked, errors);
    if (errors == 0 && pending_chars.size() == 0) begin
      $display("** number_to_ascii_digits: PASSED **");
    end else begin
      $display("** number_to_ascii_digits: FAILED **");
    end
    $finish;
  end

endmodule
